// File: sv/assert_macros.svh
// Assertion helper macros for the RTL files.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Types and constants of the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  // Decoder modes.
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;
  localparam logic [1:0] MODE_DEC   = 2'd3;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Control bytes produced by the letter escapes.
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // Digits expected by the numeric escapes.
  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] DEC_DIGITS = 2'd3;

  // Result queue depth.
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } res_t;

endpackage

// File: sv/bed_if.sv
// ----------------------------------------------------------------------------
// bed_if
// Valid/ready channels of the backslash escape decoder: raw input bytes and
// decoded result bytes.
// ----------------------------------------------------------------------------

// Raw input channel.
interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

// Decoded result channel.
interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// File: sv/backslash_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// Unescapes a backslash-escaped byte string, one raw byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw byte per item together with string_end, which marks
//   the last byte of a string; after that byte any pending escape is dropped.
//   out_ch carries decoded bytes; run_last is set on the last result that one
//   input item causes. An item causes zero, one or two results.
//   Path: an accepted item is held in the input register, is decoded into
//   the two-entry result queue once the queue has room, and its first result
//   is then offered on out_ch from the queue head.
//   Throughput: one item per cycle while each item gives at most one result
//   and the receiver takes each result. The queue drains one result per
//   cycle while out_ch.ready holds, and a two-result item may pause the input.
//   Reset (rst_n low, synchronous) returns the decoder to plain text and
//   empties the input register and the result queue.
//   When the receiver stalls, results wait in the queue; once the queue has
//   no room for the next item's results, in_ch.ready drops and the input
//   register holds its item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module backslash_escape_decoder_top (
  input logic     clk,
  input logic     rst_n,
  bed_in_if.sink  in_ch,
  bed_out_if.source out_ch
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_fire;

  // Decoder state.
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] left_r, left_nxt;
  logic [7:0] value_r, value_nxt;

  // Result queue.
  bed_pkg::res_t q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  // Decode outputs.
  bed_pkg::res_t res0, res1;
  logic [1:0]    res_n;

  // Digit recognition.
  logic       is_dec, is_lhex, is_uhex, is_digit;
  logic [7:0] dec_diff, lhex_diff, uhex_diff;
  logic [3:0] dig;
  logic [7:0] acc_val;
  logic [1:0] left_dec;
  logic [7:0] plain_byte;
  logic       plain_emit;

  // Queue bookkeeping.
  logic       pop;
  logic [1:0] cnt_pop;
  logic [1:0] room;
  bed_pkg::res_t sh0;

  // Input handshake: the register takes a new item when it is empty or its item moves on.
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.in_byte;
      s1_end_r  <= in_ch.string_end;
    end
  end

  // Digit classification of the held byte.
  always_comb begin
    dec_diff  = s1_byte_r - bed_pkg::CH_0;
    lhex_diff = s1_byte_r - (bed_pkg::CH_LA - 8'd10);
    uhex_diff = s1_byte_r - (bed_pkg::CH_UA - 8'd10);
    is_dec    = (s1_byte_r >= bed_pkg::CH_0) && (s1_byte_r <= bed_pkg::CH_9);
    is_lhex   = (s1_byte_r >= bed_pkg::CH_LA) && (s1_byte_r <= bed_pkg::CH_LF);
    is_uhex   = (s1_byte_r >= bed_pkg::CH_UA) && (s1_byte_r <= bed_pkg::CH_UF);
    if (is_lhex) begin
      dig = lhex_diff[3:0];
    end else if (is_uhex) begin
      dig = uhex_diff[3:0];
    end else begin
      dig = dec_diff[3:0];
    end
    if (mode_r == bed_pkg::MODE_HEX) begin
      is_digit = is_dec || is_lhex || is_uhex;
      acc_val  = {value_r[3:0], dig};
    end else begin
      is_digit = is_dec;
      acc_val  = {value_r[4:0], 3'b000} + {value_r[6:0], 1'b0} + {4'd0, dig};
    end
    left_dec   = left_r - 2'd1;
    plain_emit = (s1_byte_r != bed_pkg::CH_BSLASH);
    plain_byte = s1_byte_r;
  end

  // Decode step: next state and up to two results.
  always_comb begin
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    value_nxt = value_r;
    res0      = '{out_byte: value_r, run_last: 1'b1};
    res1      = '{out_byte: plain_byte, run_last: 1'b1};
    res_n     = 2'd0;
    case (mode_r)
      bed_pkg::MODE_HEX, bed_pkg::MODE_DEC: begin
        if (is_digit && (left_r != 2'd0)) begin
          value_nxt = acc_val;
          left_nxt  = left_dec;
          if (left_dec == 2'd0) begin
            res0     = '{out_byte: acc_val, run_last: 1'b1};
            res_n    = 2'd1;
            mode_nxt = bed_pkg::MODE_PLAIN;
          end
        end else begin
          // Escape cut short: emit the partial value, then the byte as text, or start a new escape on a backslash.
          left_nxt = 2'd0;
          mode_nxt = bed_pkg::MODE_PLAIN;
          res_n    = 2'd1;
          if (!is_digit) begin
            if (plain_emit) begin
              res0.run_last = 1'b0;
              res_n         = 2'd2;
            end else begin
              mode_nxt = bed_pkg::MODE_ESC;
            end
          end
        end
      end
      bed_pkg::MODE_ESC: begin
        mode_nxt = bed_pkg::MODE_PLAIN;
        res_n    = 2'd1;
        case (s1_byte_r)
          bed_pkg::CH_N:      res0.out_byte = bed_pkg::BYTE_LF;
          bed_pkg::CH_R:      res0.out_byte = bed_pkg::BYTE_CR;
          bed_pkg::CH_T:      res0.out_byte = bed_pkg::BYTE_TAB;
          bed_pkg::CH_BSLASH: res0.out_byte = bed_pkg::CH_BSLASH;
          bed_pkg::CH_X: begin
            res_n     = 2'd0;
            mode_nxt  = bed_pkg::MODE_HEX;
            left_nxt  = bed_pkg::HEX_DIGITS;
            value_nxt = 8'd0;
          end
          bed_pkg::CH_D: begin
            res_n     = 2'd0;
            mode_nxt  = bed_pkg::MODE_DEC;
            left_nxt  = bed_pkg::DEC_DIGITS;
            value_nxt = 8'd0;
          end
          default: res_n = 2'd0;
        endcase
      end
      default: begin
        if (plain_emit) begin
          res0  = '{out_byte: plain_byte, run_last: 1'b1};
          res_n = 2'd1;
        end else begin
          mode_nxt = bed_pkg::MODE_ESC;
        end
      end
    endcase
    // End of string clears any pending escape.
    if (s1_end_r) begin
      mode_nxt  = bed_pkg::MODE_PLAIN;
      left_nxt  = 2'd0;
      value_nxt = 8'd0;
    end
  end

  // Queue room after this cycle's pop decides whether the held item moves on.
  always_comb begin
    pop     = out_ch.valid && out_ch.ready;
    cnt_pop = cnt_r - {1'b0, pop};
    room    = bed_pkg::QUEUE_DEPTH - cnt_pop;
    s1_fire = s1_valid_r && (res_n <= room);
    sh0     = pop ? q1_r : q0_r;
  end

  // Queue update: shift on pop, then append the new results behind.
  always_comb begin
    q0_nxt  = sh0;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_pop;
    if (s1_fire) begin
      cnt_nxt = cnt_pop + res_n;
      case (cnt_pop)
        2'd0: begin
          q0_nxt = res0;
          q1_nxt = res1;
        end
        2'd1: q1_nxt = res0;
        default: q1_nxt = q1_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bed_pkg::MODE_PLAIN;
      left_r  <= 2'd0;
      value_r <= 8'd0;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_fire) begin
        mode_r  <= mode_nxt;
        left_r  <= left_nxt;
        value_r <= value_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // Result channel shows the queue head.
  assign out_ch.valid    = (cnt_r != 2'd0);
  assign out_ch.out_byte = q0_r.out_byte;
  assign out_ch.run_last = q0_r.run_last;

  // Assertions.
  `ASSERT_CLK(a_queue_bound, clk, rst_n, cnt_r != 2'd3, "result queue overflow")
  `ASSERT_CLK(a_text_no_digits, clk, rst_n,
    (mode_r == bed_pkg::MODE_PLAIN || mode_r == bed_pkg::MODE_ESC) |-> left_r == 2'd0,
    "digit count left over outside a numeric escape")
  `ASSERT_CLK(a_numeric_pending, clk, rst_n,
    (mode_r == bed_pkg::MODE_HEX || mode_r == bed_pkg::MODE_DEC) |-> left_r != 2'd0,
    "numeric escape with no digits left")
  `ASSERT_CLK(a_end_resets, clk, rst_n,
    (s1_fire && s1_end_r) |=> (mode_r == bed_pkg::MODE_PLAIN && value_r == 8'd0),
    "state not cleared after end of string")

endmodule
